// ===== rtl/dpq_pkg.sv =====
// Shared types, constants and tables of the dithered palette quantizer.
// Depends on nothing; every other file refers to it by scoped names.
package dpq_pkg;

    localparam int LEVEL_W = 16;
    localparam int VAL_W   = 25;  // 255 * level + 4096 * dither, signed
    localparam int SUM_W   = 27;  // sum of three channel values, signed
    localparam int BYTE_W  = 8;
    localparam int DITH_W  = 6;
    localparam int CFG_W   = 2;

    typedef enum logic [1:0] {
        MODE_GREY   = 2'd0,
        MODE_PACKED = 2'd1,
        MODE_CUBE   = 2'd2,
        MODE_CLASS  = 2'd3
    } mode_t;

    typedef enum logic {
        REG_PALETTE_MODE  = 1'b0,
        REG_DITHER_ENABLE = 1'b1
    } reg_index_t;

    // Thresholds 0.5, 1.5 and 2.5 in units of 1 / (4096 * 255).
    localparam logic signed [SUM_W-1:0] HALF_UNIT = 27'sd522240;
    localparam logic signed [SUM_W-1:0] ONE_HALF  = 27'sd1566720;
    localparam logic signed [SUM_W-1:0] TWO_HALF  = 27'sd2611200;

    typedef struct packed {
        logic              load;
        logic [DITH_W-1:0] dither;
    } lane_ctrl_t;

    typedef struct packed {
        logic  load;
        mode_t mode;
    } merge_ctrl_t;

    localparam logic [DITH_W-1:0] BAYER_TABLE [0:63] = '{
        6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
        6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
        6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
        6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
        6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
        6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
        6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
        6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
    };

    localparam logic [3:0] CLASS_MAP [0:15] = '{
        4'd0, 4'd6,  4'd5,  4'd4,  4'd3,  4'd2,  4'd1, 4'd7,
        4'd8, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd15
    };

    // The row comes from the low bits of x, the column from the low bits of y.
    function automatic logic [DITH_W-1:0] bayer_value(input logic [2:0] row,
                                                       input logic [2:0] col);
        return BAYER_TABLE[{row, col}];
    endfunction

    // Quotient by 51 of a byte, which is always 0 to 5.
    function automatic logic [2:0] div51(input logic [BYTE_W-1:0] v);
        logic [2:0] q;
        q = 3'd0;
        if (v >= 8'd51)  q = 3'd1;
        if (v >= 8'd102) q = 3'd2;
        if (v >= 8'd153) q = 3'd3;
        if (v >= 8'd204) q = 3'd4;
        if (v >= 8'd255) q = 3'd5;
        return q;
    endfunction

endpackage

// ===== rtl/dpq_lane.sv =====
// One color channel lane: scale by 255, add the dither offset, clamp to a byte.
// Depends on dpq_pkg.
module dpq_lane (
    input  logic                                 clk,
    input  dpq_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [dpq_pkg::LEVEL_W-1:0]   level,
    output logic signed [dpq_pkg::VAL_W-1:0]     value,
    output logic        [dpq_pkg::BYTE_W-1:0]    byte_level
);

    logic signed [dpq_pkg::VAL_W-1:0] value_next;
    logic signed [dpq_pkg::VAL_W-1:0] value_reg;
    logic        [dpq_pkg::BYTE_W-1:0] byte_next;
    logic        [dpq_pkg::BYTE_W-1:0] byte_reg;

    always_comb
    begin
        value_next = $signed({{(dpq_pkg::VAL_W - dpq_pkg::LEVEL_W){level[dpq_pkg::LEVEL_W-1]}},
                              level}) * 25'sd255
                   + $signed({7'b0, ctrl.dither, 12'b0});
        // Negative values go to zero; anything at or above 256.0 saturates.
        if (value_next[dpq_pkg::VAL_W-1])
        begin
            byte_next = 8'd0;
        end
        else if (value_next[dpq_pkg::VAL_W-2:20] != '0)
        begin
            byte_next = 8'd255;
        end
        else
        begin
            byte_next = value_next[19:12];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= value_next;
            byte_reg  <= byte_next;
        end
    end

    assign value      = value_reg;
    assign byte_level = byte_reg;

endmodule

// ===== rtl/dpq_merge.sv =====
// Merging stage: combines the three channel lanes into one palette index.
// Depends on dpq_pkg.
module dpq_merge (
    input  logic                                clk,
    input  dpq_pkg::merge_ctrl_t                ctrl,
    input  logic signed [dpq_pkg::VAL_W-1:0]    red_value,
    input  logic signed [dpq_pkg::VAL_W-1:0]    green_value,
    input  logic signed [dpq_pkg::VAL_W-1:0]    blue_value,
    input  logic        [dpq_pkg::BYTE_W-1:0]   red_byte,
    input  logic        [dpq_pkg::BYTE_W-1:0]   green_byte,
    input  logic        [dpq_pkg::BYTE_W-1:0]   blue_byte,
    output logic        [dpq_pkg::BYTE_W-1:0]   index
);

    logic signed [dpq_pkg::SUM_W-1:0] r_ext, g_ext, b_ext;
    logic signed [dpq_pkg::SUM_W-1:0] sum_rg, sum_rb, sum_gb, total;
    logic [dpq_pkg::BYTE_W-1:0] max_byte;
    logic [dpq_pkg::BYTE_W-1:0] grey_idx, packed_idx, cube_idx, class_idx;
    logic [2:0] pair_bits;
    logic [3:0] code;
    logic [dpq_pkg::BYTE_W-1:0] index_next;
    logic [dpq_pkg::BYTE_W-1:0] index_reg;

    always_comb
    begin
        r_ext = dpq_pkg::SUM_W'(red_value);
        g_ext = dpq_pkg::SUM_W'(green_value);
        b_ext = dpq_pkg::SUM_W'(blue_value);

        max_byte = red_byte;
        if (green_byte > max_byte) max_byte = green_byte;
        if (blue_byte > max_byte)  max_byte = blue_byte;
        grey_idx = {1'b0, max_byte[7:1]};

        packed_idx = {red_byte[7:5], green_byte[7:5], blue_byte[7:6]};

        cube_idx = 8'(8'd36 * {5'b0, dpq_pkg::div51(red_byte)})
                 + 8'(8'd6 * {5'b0, dpq_pkg::div51(green_byte)})
                 + {5'b0, dpq_pkg::div51(blue_byte)};

        // Classification works on the unclamped dithered values.
        sum_rg = r_ext + g_ext - b_ext;
        sum_rb = r_ext - g_ext + b_ext;
        sum_gb = g_ext + b_ext - r_ext;
        total  = r_ext + g_ext + b_ext;
        pair_bits = {sum_gb > dpq_pkg::HALF_UNIT,
                     sum_rb > dpq_pkg::HALF_UNIT,
                     sum_rg > dpq_pkg::HALF_UNIT};
        if (pair_bits == 3'b000)
        begin
            code = (total > dpq_pkg::HALF_UNIT) ? 4'd7 : 4'd0;
        end
        else if (pair_bits == 3'b111)
        begin
            code = (total > dpq_pkg::TWO_HALF) ? 4'd15 : 4'd8;
        end
        else
        begin
            code = {total > dpq_pkg::ONE_HALF, pair_bits};
        end
        class_idx = {4'b0, dpq_pkg::CLASS_MAP[code]};

        case (ctrl.mode)
            dpq_pkg::MODE_GREY:   index_next = grey_idx;
            dpq_pkg::MODE_PACKED: index_next = packed_idx;
            dpq_pkg::MODE_CUBE:   index_next = cube_idx;
            dpq_pkg::MODE_CLASS:  index_next = class_idx;
            default:              index_next = packed_idx;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            index_reg <= index_next;
        end
    end

    assign index = index_reg;

endmodule

// ===== rtl/dithered_palette_quantizer_top.sv =====
// Dithered palette quantizer, top level: three channel lanes and a merging stage.
// An accepted word is held in the lane registers, then in the merge index register that drives the output.
// Throughput: one word per cycle while out_stall is low, set by the two-register pipeline with no loop in it.
// Reset: rst_n clears the pipeline valid flags and loads palette_mode = 1, dither_enable = 1.
// Depends on dpq_pkg, dpq_lane and dpq_merge.
module dithered_palette_quantizer_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic        [dpq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic        [11:0]                   pixel_x,
    input  logic        [11:0]                   pixel_y,
    input  logic signed [dpq_pkg::LEVEL_W-1:0]   red_level,
    input  logic signed [dpq_pkg::LEVEL_W-1:0]   green_level,
    input  logic signed [dpq_pkg::LEVEL_W-1:0]   blue_level,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [dpq_pkg::BYTE_W-1:0]    palette_index
);

    dpq_pkg::mode_t mode_reg;
    logic           dither_en_reg;
    logic           s1_valid_reg, s1_valid_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_ready;
    logic           in_fire;
    logic           out_load;

    dpq_pkg::lane_ctrl_t  lane_ctrl;
    dpq_pkg::merge_ctrl_t merge_ctrl;

    logic signed [dpq_pkg::LEVEL_W-1:0] lane_level [3];
    logic signed [dpq_pkg::VAL_W-1:0]   lane_value [3];
    logic        [dpq_pkg::BYTE_W-1:0]  lane_byte  [3];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= dpq_pkg::MODE_PACKED;
            dither_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpq_pkg::REG_PALETTE_MODE:  mode_reg      <= dpq_pkg::mode_t'(cfg_data);
                dpq_pkg::REG_DITHER_ENABLE: dither_en_reg <= cfg_data[0];
                default:                    mode_reg      <= mode_reg;
            endcase
        end
    end

    // Two-stage pipeline; each stage moves when the one after it is free or draining.
    always_comb
    begin
        out_ready = !out_valid_reg || !out_stall;
        in_stall  = s1_valid_reg && !out_ready;
        in_fire   = in_valid && !in_stall;
        out_load  = s1_valid_reg && out_ready;

        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        lane_ctrl.load   = in_fire;
        lane_ctrl.dither = dither_en_reg ? dpq_pkg::bayer_value(pixel_x[2:0], pixel_y[2:0])
                                         : '0;
        merge_ctrl.load  = out_load;
        merge_ctrl.mode  = mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign lane_level[0] = red_level;
    assign lane_level[1] = green_level;
    assign lane_level[2] = blue_level;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        dpq_lane u_lane (
            .clk        (clk),
            .ctrl       (lane_ctrl),
            .level      (lane_level[i]),
            .value      (lane_value[i]),
            .byte_level (lane_byte[i])
        );
    end

    dpq_merge u_merge (
        .clk         (clk),
        .ctrl        (merge_ctrl),
        .red_value   (lane_value[0]),
        .green_value (lane_value[1]),
        .blue_value  (lane_value[2]),
        .red_byte    (lane_byte[0]),
        .green_byte  (lane_byte[1]),
        .blue_byte   (lane_byte[2]),
        .index       (palette_index)
    );

    assign out_valid = out_valid_reg;

    // The input side only stalls when both stages hold words and the output is blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    // An accepted word always lands in the lane registers.
    a_accept_fills_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted word lost before the lane stage");

    // A word in the lanes moves on at once when the output register is empty.
    a_lane_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("lane word not moved into an empty output register");

endmodule
